### hdl/key_sort_with_index_macros.svh
// ----------------------------------------------------------------------------
// key_sort_with_index assertion macros
// Shared concurrent assertion forms used by the sort block's modules.
// ----------------------------------------------------------------------------
`ifndef KEY_SORT_WITH_INDEX_MACROS_SVH
`define KEY_SORT_WITH_INDEX_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ksi_pkg.sv
// ----------------------------------------------------------------------------
// ksi_pkg
// Types and constants shared by the key sort controller, datapath and top.
// ----------------------------------------------------------------------------
package ksi_pkg;

  localparam int KEY_W   = 64;
  localparam int IDX_W   = 5;
  localparam int ENTRY_W = KEY_W + IDX_W;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    last_in;
  } key_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] sorted_key;
    idx_t                    original_index;
    logic                    last_out;
    logic                    dropped;
  } key_result_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    idx_t                    idx;
  } entry_t;

  typedef struct packed {
    logic load;
    logic init_ptrs;
    logic rd_i;
    logic ld_cur;
    logic inner;
    logic wr_i;
    logic rd_k;
    logic ld_out;
    logic next_k;
    logic clear_set;
  } ctrl_cmd_t;

  typedef struct packed {
    logic multi;
    logic inner_more;
    logic outer_more;
    logic emit_last;
  } ctrl_status_t;

endpackage

### hdl/key_sort_with_index.sv
// ----------------------------------------------------------------------------
// key_sort_with_index
// Loads a set of signed Q32.32 keys, exchange sorts them ascending and
// returns each key with its arrival index.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   in_item_i (key, last_in)
// out      output     out_valid_o / out_stall_i out_result_o (sorted_key,
//                                               original_index, last_out,
//                                               dropped)
//
// Keys are loaded while in_valid_i is high. The sort makes one outer pass for
// each position but the last, comparing the held key with every later key,
// one compare per cycle in the key store. Results are read from the store
// and registered one at a time, each held valid until out_stall_i is low.
// Reset clears the set count, the overflow flag and the sequencer.
// Input is stalled from the final key until the last result is transferred.
// ----------------------------------------------------------------------------
module key_sort_with_index #(
  parameter int MAX_ITEMS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ksi_pkg::key_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ksi_pkg::key_result_t out_result_o
);

  ksi_pkg::ctrl_cmd_t    cmd;
  ksi_pkg::ctrl_status_t status;

  ksi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_item_i.last_in),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  ksi_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .in_item_i (in_item_i),
    .result_o  (out_result_o)
  );

endmodule

### hdl/ksi_ram.sv
// ----------------------------------------------------------------------------
// ksi_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ksi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ksi_datapath.sv
// ----------------------------------------------------------------------------
// ksi_datapath
// Key store, set counters, compare and swap logic and the result register.
// ----------------------------------------------------------------------------
module ksi_datapath #(
  parameter int MAX_ITEMS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ksi_pkg::ctrl_cmd_t    cmd_i,
  output ksi_pkg::ctrl_status_t status_o,
  input  ksi_pkg::key_item_t    in_item_i,
  output ksi_pkg::key_result_t  result_o
);

  `include "key_sort_with_index_macros.svh"

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int AW = $clog2(MAX_ITEMS);

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] k_q, k_d;
  ksi_pkg::entry_t      cur_q, cur_d;
  ksi_pkg::key_result_t result_q, result_d;

  logic [CW-1:0] i_inc, j_inc, k_inc, count_inc;
  logic          full;
  logic          swap;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [ksi_pkg::ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [ksi_pkg::ENTRY_W-1:0] ram_rdata;
  ksi_pkg::entry_t             rd_ent;
  ksi_pkg::entry_t             new_ent;

  assign i_inc     = i_q + CW'(1);
  assign j_inc     = j_q + CW'(1);
  assign k_inc     = k_q + CW'(1);
  assign count_inc = count_q + CW'(1);
  assign full      = (count_q == CW'(MAX_ITEMS));

  assign rd_ent  = ksi_pkg::entry_t'(ram_rdata);
  assign new_ent = '{key: in_item_i.key, idx: ksi_pkg::idx_t'(count_q)};
  assign swap    = ($signed(cur_q.key) > $signed(rd_ent.key));

  assign status_o.multi      = (count_q != '0);
  assign status_o.inner_more = (({1'b0, j_q} + (CW+1)'(1)) < {1'b0, count_q});
  assign status_o.outer_more = (({1'b0, i_q} + (CW+1)'(2)) < {1'b0, count_q});
  assign status_o.emit_last  = (({1'b0, k_q} + (CW+1)'(1)) == {1'b0, count_q});

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[AW-1:0];
    ram_wdata = new_ent;
    ram_raddr = i_q[AW-1:0];
    priority if (cmd_i.load) begin
      ram_we = !full;
    end else if (cmd_i.inner) begin
      ram_we    = swap;
      ram_waddr = j_q[AW-1:0];
      ram_wdata = cur_q;
      ram_raddr = j_inc[AW-1:0];
    end else if (cmd_i.wr_i) begin
      ram_we    = 1'b1;
      ram_waddr = i_q[AW-1:0];
      ram_wdata = cur_q;
      ram_raddr = i_inc[AW-1:0];
    end else if (cmd_i.ld_cur) begin
      ram_raddr = i_inc[AW-1:0];
    end else if (cmd_i.rd_i) begin
      ram_raddr = i_q[AW-1:0];
    end else if (cmd_i.rd_k) begin
      ram_raddr = k_q[AW-1:0];
    end else begin
      ram_raddr = i_q[AW-1:0];
    end
  end

  always_comb begin
    count_d  = count_q;
    ovf_d    = ovf_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    cur_d    = cur_q;
    result_d = result_q;
    if (cmd_i.load) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_inc;
      end
    end
    if (cmd_i.init_ptrs) begin
      i_d = '0;
      k_d = '0;
    end
    if (cmd_i.ld_cur) begin
      cur_d = rd_ent;
      j_d   = i_inc;
    end
    if (cmd_i.inner) begin
      if (swap) begin
        cur_d = rd_ent;
      end
      if (status_o.inner_more) begin
        j_d = j_inc;
      end
    end
    if (cmd_i.wr_i) begin
      i_d = i_inc;
    end
    if (cmd_i.ld_out) begin
      result_d.sorted_key     = rd_ent.key;
      result_d.original_index = rd_ent.idx;
      result_d.last_out       = status_o.emit_last;
      result_d.dropped        = status_o.emit_last & ovf_q;
    end
    if (cmd_i.next_k) begin
      k_d = k_inc;
    end
    if (cmd_i.clear_set) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    result_q <= result_d;
  end

  ksi_ram #(
    .WIDTH (ksi_pkg::ENTRY_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign result_o = result_q;

  `KSI_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(MAX_ITEMS),
                  "Set count exceeds capacity.")
  `KSI_ASSERT_NOW(a_inner_in_set, cmd_i.inner, j_q < count_q,
                  "Inner compare beyond the loaded set.")
  `KSI_ASSERT_NEXT(a_clear_empties, cmd_i.clear_set, count_q == '0 && !ovf_q,
                   "Set not emptied after the final result.")

endmodule

### hdl/ksi_ctrl.sv
// ----------------------------------------------------------------------------
// ksi_ctrl
// Sequencer for loading, exchange sorting and emitting one set of keys.
// ----------------------------------------------------------------------------
module ksi_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_last_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ksi_pkg::ctrl_cmd_t    cmd_o,
  input  ksi_pkg::ctrl_status_t status_i
);

  `include "key_sort_with_index_macros.svh"

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_RDI   = 3'd1;
  localparam logic [2:0] S_LDI   = 3'd2;
  localparam logic [2:0] S_INNER = 3'd3;
  localparam logic [2:0] S_WRI   = 3'd4;
  localparam logic [2:0] S_ERD   = 3'd5;
  localparam logic [2:0] S_EOUT  = 3'd6;
  localparam logic [2:0] S_EHOLD = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.init_ptrs = 1'b1;
            state_d = status_i.multi ? S_RDI : S_ERD;
          end
        end
      end
      S_RDI: begin
        cmd_o.rd_i = 1'b1;
        state_d = S_LDI;
      end
      S_LDI: begin
        cmd_o.ld_cur = 1'b1;
        state_d = S_INNER;
      end
      S_INNER: begin
        cmd_o.inner = 1'b1;
        if (!status_i.inner_more) begin
          state_d = S_WRI;
        end
      end
      S_WRI: begin
        cmd_o.wr_i = 1'b1;
        state_d = status_i.outer_more ? S_LDI : S_ERD;
      end
      S_ERD: begin
        cmd_o.rd_k = 1'b1;
        state_d = S_EOUT;
      end
      S_EOUT: begin
        cmd_o.ld_out = 1'b1;
        state_d = S_EHOLD;
      end
      S_EHOLD: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (status_i.emit_last) begin
            cmd_o.clear_set = 1'b1;
            state_d = S_LOAD;
          end else begin
            cmd_o.next_k = 1'b1;
            state_d = S_ERD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  `KSI_ASSERT_NOW(a_out_blocks_in, out_valid_o, in_stall_o,
                  "Input taken while a result is pending.")
  `KSI_ASSERT_NEXT(a_sort_after_last,
                   state_q == S_LOAD && in_valid_i && in_last_i,
                   state_q == S_RDI || state_q == S_ERD,
                   "Final key did not start the sort.")

endmodule
